/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the charset detector.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/jcd_pkg.sv */
// ---------------------------------------------------------------------------
// jcd_pkg
// Types and constants shared by the Japanese charset detector modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jcd_pkg;

   // Verdict codes
   typedef enum logic [2:0] {
      ENC_UNKNOWN = 3'd0,
      ENC_ASCII   = 3'd1,
      ENC_EUCJP   = 3'd2,
      ENC_JIS     = 3'd3,
      ENC_SJIS    = 3'd4,
      ENC_UTF8    = 3'd5
   } encoding_type;

   // Register map (word index)
   localparam logic CSR_SCAN_LIMIT = 1'b0;
   localparam logic [15:0] SCAN_LIMIT_RESET = 16'd1024;

   // Special byte values
   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_DEL = 8'h7F;
   localparam logic [7:0] EUC_SS2  = 8'h8E;
   localparam logic [7:0] EUC_SS3  = 8'h8F;

endpackage

/* design/jcd_csr.sv */
// ---------------------------------------------------------------------------
// jcd_csr
// APB-style register block holding the scan limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcd_csr import jcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] scan_limit
);

   logic [15:0] scan_limit_ff;
   logic [15:0] scan_limit_in;
   logic        write_hit;

   // Decode a completed write to the limit register
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_SCAN_LIMIT);

   always_comb begin
      scan_limit_in = scan_limit_ff;
      if (write_hit) begin
         scan_limit_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_LIMIT_RESET;
      end else begin
         scan_limit_ff <= scan_limit_in;
      end
   end

   // Read back; unmapped word reads as zero
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_SCAN_LIMIT) begin
         csr_prdata = {16'd0, scan_limit_ff};
      end
   end

   assign scan_limit = scan_limit_ff;

endmodule

/* design/jcd_scan.sv */
// ---------------------------------------------------------------------------
// jcd_scan
// Per-text scan state: escape and high-byte tracking, the UTF-8, EUC-JP and
// SJIS validators, and the verdict for the closing word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jcd_scan import jcd_pkg::*; #(
   parameter int unsigned POSITION_WIDTH = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         word_accept,
   input  logic [7:0]   data_byte,
   input  logic         last_byte,
   input  logic [15:0]  scan_limit,
   output encoding_type verdict
);

   localparam int unsigned CMP_WIDTH = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   typedef enum logic [2:0] {
      EUC_LEAD       = 3'd0,
      EUC_KANA       = 3'd1,
      EUC_SS3_FIRST  = 3'd2,
      EUC_SS3_SECOND = 3'd3,
      EUC_KANJI      = 3'd4
   } euc_phase_type;

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic          high_ff, high_in;
   logic          esc_ff, esc_in;
   logic          utf8_valid_ff, utf8_valid_in;
   logic [1:0]    utf8_pend_ff, utf8_pend_in;
   logic          euc_valid_ff, euc_valid_in;
   euc_phase_type euc_phase_ff, euc_phase_in;
   logic          sjis_valid_ff, sjis_valid_in;
   logic          sjis_pend_ff, sjis_pend_in;

   logic in_window;
   logic is_high;
   logic euc_multi;
   logic utf8_ok, euc_ok, sjis_ok;

   assign in_window = CMP_WIDTH'(pos_ff) < CMP_WIDTH'(scan_limit);
   assign is_high   = data_byte[7];
   assign euc_multi = (data_byte >= 8'hA1) && (data_byte <= 8'hFE);

   // Escape / high-byte tracking and position
   always_comb begin
      high_in = high_ff;
      esc_in  = esc_ff;
      if (in_window && !high_ff && !esc_ff) begin
         if (data_byte == BYTE_ESC) begin
            esc_in = 1'b1;
         end else if (is_high) begin
            high_in = 1'b1;
         end
      end
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   end

   // UTF-8 validator
   always_comb begin
      utf8_valid_in = utf8_valid_ff;
      utf8_pend_in  = utf8_pend_ff;
      if (utf8_valid_ff) begin
         if (utf8_pend_ff != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
               utf8_valid_in = 1'b0;
               utf8_pend_in  = 2'd0;
            end else begin
               utf8_pend_in = utf8_pend_ff - 2'd1;
            end
         end else if (in_window && is_high) begin
            if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
               utf8_pend_in = 2'd1;
            end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
               utf8_pend_in = 2'd2;
            end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
               utf8_pend_in = 2'd3;
            end else begin
               utf8_valid_in = 1'b0;
            end
         end
      end
   end

   // EUC-JP validator
   always_comb begin
      euc_valid_in = euc_valid_ff;
      euc_phase_in = euc_phase_ff;
      if (euc_valid_ff) begin
         unique case (euc_phase_ff)
            EUC_KANA: begin
               euc_phase_in = EUC_LEAD;
               if (!(data_byte >= 8'hA1 && data_byte <= 8'hDF)) begin
                  euc_valid_in = 1'b0;
               end
            end
            EUC_SS3_FIRST: begin
               euc_phase_in = EUC_SS3_SECOND;
               if (!euc_multi) begin
                  euc_valid_in = 1'b0;
                  euc_phase_in = EUC_LEAD;
               end
            end
            EUC_SS3_SECOND, EUC_KANJI: begin
               euc_phase_in = EUC_LEAD;
               if (!euc_multi) begin
                  euc_valid_in = 1'b0;
               end
            end
            default: begin
               euc_phase_in = EUC_LEAD;
               if (in_window && is_high) begin
                  if (data_byte == EUC_SS2) begin
                     euc_phase_in = EUC_KANA;
                  end else if (data_byte == EUC_SS3) begin
                     euc_phase_in = EUC_SS3_FIRST;
                  end else if (euc_multi) begin
                     euc_phase_in = EUC_KANJI;
                  end else begin
                     euc_valid_in = 1'b0;
                  end
               end
            end
         endcase
      end
   end

   // SJIS validator
   always_comb begin
      sjis_valid_in = sjis_valid_ff;
      sjis_pend_in  = sjis_pend_ff;
      if (sjis_valid_ff) begin
         if (sjis_pend_ff) begin
            sjis_pend_in = 1'b0;
            if (data_byte < 8'h40 || data_byte > 8'hFC || data_byte == BYTE_DEL) begin
               sjis_valid_in = 1'b0;
            end
         end else if (in_window && is_high && !(data_byte >= 8'hA1 && data_byte <= 8'hDF)) begin
            if ((data_byte >= 8'h81 && data_byte <= 8'h9F)
                || (data_byte >= 8'hE0 && data_byte <= 8'hFC)) begin
               sjis_pend_in = 1'b1;
            end else begin
               sjis_valid_in = 1'b0;
            end
         end
      end
   end

   // Verdict: a character still open at the end fails its validator
   assign utf8_ok = utf8_valid_in && (utf8_pend_in == 2'd0);
   assign euc_ok  = euc_valid_in && (euc_phase_in == EUC_LEAD);
   assign sjis_ok = sjis_valid_in && !sjis_pend_in;

   always_comb begin
      if (esc_in) begin
         verdict = ENC_JIS;
      end else if (!high_in && in_window) begin
         verdict = ENC_ASCII;
      end else if (utf8_ok) begin
         verdict = ENC_UTF8;
      end else if (euc_ok) begin
         verdict = ENC_EUCJP;
      end else if (sjis_ok) begin
         verdict = ENC_SJIS;
      end else begin
         verdict = ENC_UNKNOWN;
      end
   end

   // Advance on each word; clear after the closing word
   always_ff @(posedge clock) begin
      if (reset || (word_accept && last_byte)) begin
         pos_ff        <= '0;
         high_ff       <= 1'b0;
         esc_ff        <= 1'b0;
         utf8_valid_ff <= 1'b1;
         utf8_pend_ff  <= 2'd0;
         euc_valid_ff  <= 1'b1;
         euc_phase_ff  <= EUC_LEAD;
         sjis_valid_ff <= 1'b1;
         sjis_pend_ff  <= 1'b0;
      end else if (word_accept) begin
         pos_ff        <= pos_in;
         high_ff       <= high_in;
         esc_ff        <= esc_in;
         utf8_valid_ff <= utf8_valid_in;
         utf8_pend_ff  <= utf8_pend_in;
         euc_valid_ff  <= euc_valid_in;
         euc_phase_ff  <= euc_phase_in;
         sjis_valid_ff <= sjis_valid_in;
         sjis_pend_ff  <= sjis_pend_in;
      end
   end

   // A failed validator never holds an open character
   `ASSERT_CLK(a_utf8_pend_valid, clock, reset, (utf8_pend_ff != 2'd0) |-> utf8_valid_ff, "utf8")
   `ASSERT_CLK(a_euc_phase_valid, clock, reset, (euc_phase_ff != EUC_LEAD) |-> euc_valid_ff, "euc")
   `ASSERT_CLK(a_sjis_pend_valid, clock, reset, sjis_pend_ff |-> sjis_valid_ff, "sjis open")

endmodule

/* design/japanese_charset_detector.sv */
// ---------------------------------------------------------------------------
// japanese_charset_detector
// Byte-stream Japanese encoding detector: one verdict per text, given with
// the byte flagged last.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req_     in         req_valid / req_stall  req_data_byte[7:0], req_last_byte
//  rsp_     out        rsp_valid / rsp_stall  rsp_encoding[2:0]
//  csr_     in/out     APB psel/penable       scan_limit at byte address 0
//
//  One byte is taken every cycle while req_stall is low; the scan state updates in that same cycle.
//  The verdict is registered into the output buffer as the closing byte is taken, behind any older verdicts.
//  Synchronous reset clears the scan state and sets scan_limit to 1024.
//  A two-word output buffer decouples the sides; req_stall rises only when
//  both words are held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module japanese_charset_detector import jcd_pkg::*; #(
   parameter int unsigned POSITION_WIDTH = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_encoding,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]  scan_limit;
   encoding_type verdict;
   logic         req_accept, push, pop;

   logic         head_valid_ff, head_valid_in;
   encoding_type head_enc_ff, head_enc_in;
   logic         skid_valid_ff, skid_valid_in;
   encoding_type skid_enc_ff, skid_enc_in;

   jcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .scan_limit  (scan_limit)
   );

   jcd_scan #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .word_accept (req_accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .scan_limit  (scan_limit),
      .verdict     (verdict)
   );

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign push       = req_accept && req_last_byte;
   assign pop        = head_valid_ff && !rsp_stall;

   // Output buffer: head word shown, skid word behind it
   always_comb begin
      head_valid_in = head_valid_ff;
      head_enc_in   = head_enc_ff;
      skid_valid_in = skid_valid_ff;
      skid_enc_in   = skid_enc_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_enc_in   = skid_enc_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_enc_in   = verdict;
         end
         if (push && skid_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_enc_in   = verdict;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_enc_in   = verdict;
         end else begin
            skid_valid_in = 1'b1;
            skid_enc_in   = verdict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_enc_ff <= head_enc_in;
      skid_enc_ff <= skid_enc_in;
   end

   assign rsp_valid    = head_valid_ff;
   assign rsp_encoding = head_enc_ff;

   // Buffer ordering and occupancy checks
   `ASSERT_CLK(a_skid_needs_head, clock, reset, skid_valid_ff |-> head_valid_ff, "skid word without head word")
   `ASSERT_CLK(a_skid_holds, clock, reset, (skid_valid_ff && !pop) |=> skid_valid_ff, "skid word lost")
   `ASSERT_CLK(a_push_shows, clock, reset, push |=> head_valid_ff, "verdict not shown after closing byte")

endmodule

/* verif/japanese_charset_detector_tb.sv */
// ---------------------------------------------------------------------------
// japanese_charset_detector_tb
// Feeds byte texts into the charset detector under random gaps and stalls,
// predicts every verdict from its own scan of each accepted byte word and
// compares it with each verdict word returned. The scan limit register is
// set between phases, including zero, one, the reset value and the maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module japanese_charset_detector_tb;
   import jcd_pkg::*;

   localparam int          POS_W        = 17;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int          PHASE_BYTES  = 120;
   localparam logic [2:0]  SCAN_LIMIT_ADDR = {CSR_SCAN_LIMIT, 2'b00};

   typedef enum int {TXT_ASCII, TXT_UTF8, TXT_EUC, TXT_SJIS, TXT_NOISE} text_kind_type;

   typedef enum logic [2:0] {
      EUC_LEAD, EUC_KANA, EUC_SS3_FIRST, EUC_SS3_SECOND, EUC_KANJI
   } euc_state_type;

   typedef struct {
      logic [7:0]  data;
      logic        last;
      int unsigned gap;
   } text_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_encoding;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Pending byte words and the verdicts still owed
   text_word_type text_q[$];
   encoding_type  verdict_q[$];
   int            fail_count = 0;

   // Driver staging
   text_word_type next_word;
   int unsigned   gap_left = 0;
   logic          staged = 1'b0;

   // Receiver stall control
   logic        long_hold_req = 1'b0;
   logic        long_hold_done = 1'b0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;
   int unsigned rsp_pick;
   int unsigned idle_cycles = 0;

   // Predicted detector state
   logic [15:0]      scan_window = SCAN_LIMIT_RESET;
   logic [POS_W-1:0] scan_pos;
   logic             hi_seen, esc_seen;
   logic             u8_ok, euc_ok, sj_ok, sj_trail;
   logic [1:0]       u8_left;
   euc_state_type    euc_st;

   japanese_charset_detector #(
      .POSITION_WIDTH(POS_W)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_encoding  (rsp_encoding),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit between(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
      return b >= lo && b <= hi;
   endfunction

   // Return the scan to its start-of-text values
   function automatic void clear_scan();
      scan_pos = '0;
      hi_seen  = 1'b0;
      esc_seen = 1'b0;
      u8_ok    = 1'b1;
      u8_left  = '0;
      euc_ok   = 1'b1;
      euc_st   = EUC_LEAD;
      sj_ok    = 1'b1;
      sj_trail = 1'b0;
   endfunction

   // Advance the predicted scan by one byte; owe a verdict on the closing byte
   function automatic void scan_byte(logic [7:0] b, logic last);
      logic         in_window;
      logic         multi;
      encoding_type verdict;
      in_window = scan_pos < POS_W'(scan_window);
      multi     = between(b, 8'hA1, 8'hFE);

      if (in_window && !hi_seen && !esc_seen) begin
         if (b == BYTE_ESC) esc_seen = 1'b1;
         else if (b[7]) hi_seen = 1'b1;
      end

      // UTF-8: trailing bytes are checked even past the window
      if (u8_ok) begin
         if (u8_left != 0) begin
            if (b[7:6] != 2'b10) begin
               u8_ok   = 1'b0;
               u8_left = '0;
            end else begin
               u8_left--;
            end
         end else if (in_window && b[7]) begin
            if (between(b, 8'hC2, 8'hDF)) u8_left = 2'd1;
            else if (between(b, 8'hE0, 8'hEF)) u8_left = 2'd2;
            else if (between(b, 8'hF0, 8'hF4)) u8_left = 2'd3;
            else u8_ok = 1'b0;
         end
      end

      // EUC-JP
      if (euc_ok) begin
         case (euc_st)
            EUC_KANA: begin
               euc_st = EUC_LEAD;
               if (!between(b, 8'hA1, 8'hDF)) euc_ok = 1'b0;
            end
            EUC_SS3_FIRST: begin
               if (multi) begin
                  euc_st = EUC_SS3_SECOND;
               end else begin
                  euc_ok = 1'b0;
                  euc_st = EUC_LEAD;
               end
            end
            EUC_SS3_SECOND, EUC_KANJI: begin
               euc_st = EUC_LEAD;
               if (!multi) euc_ok = 1'b0;
            end
            default: begin
               if (in_window && b[7]) begin
                  if (b == EUC_SS2) euc_st = EUC_KANA;
                  else if (b == EUC_SS3) euc_st = EUC_SS3_FIRST;
                  else if (multi) euc_st = EUC_KANJI;
                  else euc_ok = 1'b0;
               end
            end
         endcase
      end

      // SJIS: half-width kana stand alone
      if (sj_ok) begin
         if (sj_trail) begin
            sj_trail = 1'b0;
            if (!between(b, 8'h40, 8'hFC) || b == BYTE_DEL) sj_ok = 1'b0;
         end else if (in_window && b[7] && !between(b, 8'hA1, 8'hDF)) begin
            if (between(b, 8'h81, 8'h9F) || between(b, 8'hE0, 8'hFC)) sj_trail = 1'b1;
            else sj_ok = 1'b0;
         end
      end

      if (!last) begin
         if (scan_pos != '1) scan_pos++;
      end else begin
         // A character cut off by the end of text fails its validator
         if (u8_left != 0) u8_ok = 1'b0;
         if (euc_st != EUC_LEAD) euc_ok = 1'b0;
         if (sj_trail) sj_ok = 1'b0;

         if (esc_seen) verdict = ENC_JIS;
         else if (!hi_seen && in_window) verdict = ENC_ASCII;
         else if (u8_ok) verdict = ENC_UTF8;
         else if (euc_ok) verdict = ENC_EUCJP;
         else if (sj_ok) verdict = ENC_SJIS;
         else verdict = ENC_UNKNOWN;
         verdict_q = {verdict_q, verdict};
         clear_scan();
      end
   endfunction

   // Sender gap before a word: mostly none, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int push_text(input logic [7:0] txt[$], input bit burst);
      text_word_type w;
      for (int i = 0; i < txt.size(); i++) begin
         w.data = txt[i];
         w.last = (i == txt.size() - 1);
         w.gap  = burst ? 0 : pick_gap();
         text_q = {text_q, w};
      end
      return txt.size();
   endfunction

   // Build one random text, mostly well-formed for its encoding, sometimes broken
   function automatic int add_text();
      logic [7:0]    txt[$];
      logic [7:0]    trail_byte;
      text_kind_type kind;
      int            n_chars;
      int            pick;
      kind    = text_kind_type'($urandom_range(0, 4));
      n_chars = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      for (int i = 0; i < n_chars; i++) begin
         pick = $urandom_range(0, 3);
         case (kind)
            TXT_ASCII: txt = {txt, ($urandom_range(0, 9) == 0) ? BYTE_ESC
                                   : 8'($urandom_range(0, 127))};
            TXT_NOISE: txt = {txt, 8'($urandom_range(0, 255))};
            default: begin
               if (pick == 0) begin
                  txt = {txt, 8'($urandom_range(8'h20, 8'h7E))};
               end else if (kind == TXT_UTF8) begin
                  pick = $urandom_range(1, 3);
                  if (pick == 1) txt = {txt, 8'($urandom_range(8'hC2, 8'hDF))};
                  else if (pick == 2) txt = {txt, 8'($urandom_range(8'hE0, 8'hEF))};
                  else txt = {txt, 8'($urandom_range(8'hF0, 8'hF4))};
                  repeat (pick) txt = {txt, 8'($urandom_range(8'h80, 8'hBF))};
               end else if (kind == TXT_EUC) begin
                  pick = $urandom_range(0, 9);
                  if (pick == 0) begin
                     txt = {txt, EUC_SS2};
                     txt = {txt, 8'($urandom_range(8'hA1, 8'hDF))};
                  end else begin
                     if (pick == 1) txt = {txt, EUC_SS3};
                     txt = {txt, 8'($urandom_range(8'hA1, 8'hFE))};
                     txt = {txt, 8'($urandom_range(8'hA1, 8'hFE))};
                  end
               end else begin
                  pick = $urandom_range(0, 3);
                  if (pick == 0) begin
                     txt = {txt, 8'($urandom_range(8'hA1, 8'hDF))};
                  end else begin
                     txt = {txt, (pick == 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                             : 8'($urandom_range(8'hE0, 8'hFC))};
                     trail_byte = 8'($urandom_range(8'h40, 8'hFC));
                     if (trail_byte == BYTE_DEL) trail_byte = 8'h80;
                     txt = {txt, trail_byte};
                  end
               end
            end
         endcase
      end

      // Break some texts: a stray byte or a cut-off last character
      pick = $urandom_range(0, 9);
      if (pick == 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      else if (pick == 1 && txt.size() > 1) txt.delete(txt.size() - 1);
      return push_text(txt, $urandom_range(0, 3) == 0);
   endfunction

   // Write the scan limit, then read it back
   task automatic csr_write(input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SCAN_LIMIT_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      scan_window = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value) begin
         $display("%0t: scan limit readback: expected %0d, actual %0d",
                  $time, value, csr_prdata[15:0]);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold off until every word is taken and every verdict returned
   task automatic wait_idle();
      while (text_q.size() != 0 || staged || req_valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Feed byte words to the detector and predict as each word is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         staged = 1'b0;
         gap_left = 0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall) scan_byte(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (!staged && text_q.size() != 0) begin
               next_word = text_q.pop_front();
               gap_left  = next_word.gap;
               staged    = 1'b1;
            end
            if (staged && gap_left == 0) begin
               req_valid     <= 1'b1;
               req_data_byte <= next_word.data;
               req_last_byte <= next_word.last;
               staged = 1'b0;
            end else begin
               req_valid <= 1'b0;
               if (staged) gap_left--;
            end
         end
      end
   end

   // Stall the verdict side: short and long holds, calm stretches, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         calm_left = 0;
         long_hold_done = 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_left != 0) begin
            calm_left--;
         end else begin
            rsp_pick = $urandom_range(0, 99);
            if (rsp_pick < 3) calm_left = $urandom_range(20, 80);
            else if (rsp_pick < 18) stall_left = $urandom_range(1, 3);
            else if (rsp_pick < 20) stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Compare each verdict word with the oldest prediction
   always @(posedge clock) begin
      encoding_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict with none expected: expected none, actual %0d",
                     $time, rsp_encoding);
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_encoding !== want) begin
               $display("%0t: encoding mismatch: expected %0d (%s), actual %0d",
                        $time, want, want.name(), rsp_encoding);
               fail_count++;
            end
         end
      end
   end

   // Abort if no word moves on any port for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d verdicts outstanding", $time, verdict_q.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] phase_limits[$];
      int          phase_bytes;
      phase_limits = '{16'd3, 16'd65535, 16'd1, 16'd7, 16'd1024,
                       16'($urandom_range(2, 40)), 16'd12, 16'd2};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed texts at the reset limit
      void'(push_text('{8'h41}, 1'b0));
      void'(push_text('{BYTE_ESC}, 1'b0));
      void'(push_text('{8'h00, BYTE_DEL}, 1'b0));
      void'(push_text('{8'h80}, 1'b0));
      void'(push_text('{8'hFF}, 1'b0));
      void'(push_text('{8'hC3, 8'hA9}, 1'b0));
      void'(push_text('{EUC_SS2, 8'hA1}, 1'b0));
      void'(push_text('{EUC_SS3, 8'hA1, 8'hFE}, 1'b0));
      void'(push_text('{8'h82, 8'hA0}, 1'b0));
      void'(push_text('{8'hA1}, 1'b0));
      // cut-off character, and ESC after a high byte
      void'(push_text('{8'hE3}, 1'b0));
      void'(push_text('{8'h80, BYTE_ESC}, 1'b0));
      wait_idle();

      // Zero limit: nothing is examined
      csr_write(16'd0);
      void'(push_text('{8'h80, 8'hFF}, 1'b1));
      wait_idle();

      // Limit of one: long 7-bit text, ESC past the limit, trails past the limit
      csr_write(16'd1);
      void'(push_text('{8'h41, 8'h41}, 1'b0));
      void'(push_text('{8'h41, BYTE_ESC}, 1'b1));
      void'(push_text('{8'hE3, 8'h81}, 1'b0));
      wait_idle();

      // Random phases over several limits; the sender pauses between them
      foreach (phase_limits[i]) begin
         csr_write(phase_limits[i]);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) phase_bytes += add_text();
         if (i == 3) begin
            @(posedge clock);
            long_hold_req <= 1'b1;
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
